FILE: rtl/imrr_pkg.sv
// ----------------------------------------------------------------------------
// imrr_pkg
// Shared types, constants and helpers for the IPv4 match, rewrite and
// redirect block.
// ----------------------------------------------------------------------------
package imrr_pkg;

  localparam int HOLD_BYTES      = 42;
  localparam int IP_HDR_END      = 34;
  localparam int POS_W           = 6;
  localparam int SUM_W           = 20;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 48;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_SRC_IP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_DEST_IP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_SRC_MAC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_DEST_MAC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_PROTO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REDIRECT_PORT = 3'd5;

  localparam logic [31:0] RST_MATCH_SRC_IP  = 32'hc0a8_0203;
  localparam logic [31:0] RST_NEW_DEST_IP   = 32'hc0a8_0306;
  localparam logic [47:0] RST_NEW_SRC_MAC   = 48'd81810125252014;
  localparam logic [47:0] RST_NEW_DEST_MAC  = 48'd50981836629205;
  localparam logic [7:0]  RST_MATCH_PROTO   = 8'd1;
  localparam logic [15:0] RST_REDIRECT_PORT = 16'd3;

  // byte offsets within the frame
  localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [POS_W-1:0] POS_CSUM_LO   = 6'd14;
  localparam logic [POS_W-1:0] POS_PROTO     = 6'd23;
  localparam logic [POS_W-1:0] POS_CHK_HI    = 6'd24;
  localparam logic [POS_W-1:0] POS_CHK_LO    = 6'd25;
  localparam logic [POS_W-1:0] POS_SADDR_0   = 6'd26;
  localparam logic [POS_W-1:0] POS_SADDR_1   = 6'd27;
  localparam logic [POS_W-1:0] POS_SADDR_2   = 6'd28;
  localparam logic [POS_W-1:0] POS_SADDR_3   = 6'd29;
  localparam logic [POS_W-1:0] POS_DADDR_0   = 6'd30;
  localparam logic [POS_W-1:0] POS_DADDR_3   = 6'd33;
  localparam logic [POS_W-1:0] POS_LAST_HOLD = 6'(HOLD_BYTES - 1);
  localparam logic [POS_W-1:0] POS_LAST_IP   = 6'(IP_HDR_END - 1);
  localparam int               MAC_BYTES     = 6;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_frame_end;
    logic        run_end;
    logic        redirect;
    logic [15:0] port_out;
    logic [31:0] matched_count;
  } out_t;

  typedef struct packed {
    logic [31:0] match_source_ip;
    logic [31:0] new_dest_ip;
    logic [47:0] new_source_mac;
    logic [47:0] new_dest_mac;
    logic [7:0]  match_protocol;
    logic [15:0] redirect_port;
  } cfg_t;

  typedef struct packed {
    logic             is_flush;
    logic [7:0]       in_byte;
    logic             frame_end;
    logic             redirect;
    logic             rewrite;
    logic [31:0]      count;
    logic [POS_W-1:0] last_idx;
    logic [SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic mem_busy;
    logic flushed;
  } front_status_t;

  function automatic logic [15:0] csum_fold(input logic [SUM_W-1:0] sum);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, sum[15:0]} + 17'(sum[SUM_W-1:16]);
    s2 = s1[15:0] + 16'(s1[16]);
    return ~s2;
  endfunction

endpackage

FILE: rtl/imrr_front.sv
// ----------------------------------------------------------------------------
// imrr_front
// Accepts frame bytes, holds the header in a store, captures the match
// fields and the partial header sum, and queues flush and pass jobs.
// ----------------------------------------------------------------------------
module imrr_front import imrr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             req_valid,
  output logic             req_ready,
  input  in_t              req,
  input  logic             q_ready,
  output logic             q_push,
  output job_t             q_job,
  input  logic             mem_release,
  input  logic [POS_W-1:0] rd_addr,
  output logic [7:0]       rd_data,
  output front_status_t    status
);

  logic [7:0]       store [HOLD_BYTES];
  logic [POS_W-1:0] pos;
  logic             flushed;
  logic             redirect_flag;
  logic             mem_busy;
  logic [31:0]      count;
  logic [SUM_W-1:0] sum;
  logic [15:0]      etype;
  logic [31:0]      saddr;
  logic [7:0]       proto;

  logic             accept;
  logic             flush_now;
  logic             hit;
  logic             proto_hit;
  logic [31:0]      count_next;
  logic [SUM_W-1:0] sum_next;
  logic             in_sum;

  always_comb begin
    req_ready  = q_ready && (flushed || !mem_busy);
    accept     = req_valid && req_ready;
    flush_now  = !flushed && (pos == POS_LAST_HOLD || req.frame_end);
    q_push     = accept && (flushed || flush_now);
    hit        = (pos >= POS_LAST_IP) && (etype == ETHERTYPE_IPV4) &&
                 (saddr == cfg.match_source_ip);
    proto_hit  = hit && (proto == cfg.match_protocol);
    count_next = proto_hit ? count + 32'd1 : count;
    in_sum     = (pos >= POS_CSUM_LO && pos <= POS_PROTO) ||
                 (pos >= POS_SADDR_0 && pos <= POS_SADDR_3);
    sum_next   = sum;
    if (in_sum) begin
      sum_next = pos[0] ? sum + SUM_W'(req.in_byte) : sum + SUM_W'({req.in_byte, 8'h00});
    end

    q_job.is_flush  = !flushed;
    q_job.in_byte   = req.in_byte;
    q_job.frame_end = req.frame_end;
    q_job.redirect  = flushed ? redirect_flag : hit;
    q_job.rewrite   = proto_hit && (pos == POS_LAST_HOLD);
    q_job.count     = flushed ? count : count_next;
    q_job.last_idx  = pos;
    q_job.sum       = sum + SUM_W'(cfg.new_dest_ip[31:16]) + SUM_W'(cfg.new_dest_ip[15:0]);

    status.mem_busy = mem_busy;
    status.flushed  = flushed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      flushed       <= 1'b0;
      redirect_flag <= 1'b0;
      mem_busy      <= 1'b0;
      count         <= '0;
      sum           <= '0;
    end else begin
      if (mem_release) begin
        mem_busy <= 1'b0;
      end
      if (accept) begin
        if (flushed) begin
          if (req.frame_end) begin
            pos           <= '0;
            flushed       <= 1'b0;
            redirect_flag <= 1'b0;
            sum           <= '0;
          end
        end else if (flush_now) begin
          count    <= count_next;
          mem_busy <= 1'b1;
          if (req.frame_end) begin
            pos           <= '0;
            flushed       <= 1'b0;
            redirect_flag <= 1'b0;
            sum           <= '0;
          end else begin
            flushed       <= 1'b1;
            redirect_flag <= hit;
          end
        end else begin
          pos <= pos + 1'b1;
          sum <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !flushed) begin
      store[pos] <= req.in_byte;
      unique case (pos)
        POS_ETYPE_HI: etype[15:8]  <= req.in_byte;
        POS_ETYPE_LO: etype[7:0]   <= req.in_byte;
        POS_PROTO:    proto        <= req.in_byte;
        POS_SADDR_0:  saddr[31:24] <= req.in_byte;
        POS_SADDR_1:  saddr[23:16] <= req.in_byte;
        POS_SADDR_2:  saddr[15:8]  <= req.in_byte;
        POS_SADDR_3:  saddr[7:0]   <= req.in_byte;
        default: ;
      endcase
    end
    rd_data <= store[rd_addr];
  end

endmodule

FILE: rtl/imrr_queue.sv
// ----------------------------------------------------------------------------
// imrr_queue
// Small first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module imrr_queue import imrr_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic ready,
  output logic valid,
  output job_t job_out,
  input  logic pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    ready   = (count != CW'(DEPTH));
    valid   = (count != '0);
    job_out = entries[rd_ptr];
    do_push = push && ready;
    do_pop  = pop && valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= job_in;
    end
  end

endmodule

FILE: rtl/imrr_back.sv
// ----------------------------------------------------------------------------
// imrr_back
// Carries out queued jobs: streams the held header out of the store with
// rewritten fields, or passes single bytes, into the output register.
// ----------------------------------------------------------------------------
module imrr_back import imrr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             q_pop,
  output logic [POS_W-1:0] rd_addr,
  input  logic [7:0]       rd_data,
  output logic             mem_release,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output out_t             rsp
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_SEND = 1'b1;

  logic             state;
  logic             state_next;
  logic [POS_W-1:0] idx;
  logic [POS_W-1:0] idx_next;
  job_t             job;
  logic [15:0]      chk;
  logic             out_free;
  logic             load;
  logic             start;
  logic             last;
  out_t             load_data;

  function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] i, input logic rw,
                                          input cfg_t c, input logic [15:0] ck,
                                          input logic [7:0] orig);
    int k;
    logic [7:0] b;
    k = int'(i);
    b = orig;
    if (rw) begin
      priority if (k < MAC_BYTES) begin
        b = c.new_dest_mac[8*(MAC_BYTES-1-k) +: 8];
      end else if (k < 2*MAC_BYTES) begin
        b = c.new_source_mac[8*(2*MAC_BYTES-1-k) +: 8];
      end else if (i == POS_CHK_HI) begin
        b = ck[15:8];
      end else if (i == POS_CHK_LO) begin
        b = ck[7:0];
      end else if (i >= POS_DADDR_0 && i <= POS_DADDR_3) begin
        b = c.new_dest_ip[8*(int'(POS_DADDR_3)-k) +: 8];
      end else begin
        b = orig;
      end
    end
    return b;
  endfunction

  always_comb begin
    out_free    = !rsp_valid || rsp_ready;
    state_next  = state;
    idx_next    = idx;
    q_pop       = 1'b0;
    mem_release = 1'b0;
    load        = 1'b0;
    start       = 1'b0;
    last        = (idx == job.last_idx);
    load_data   = rsp;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (!q_job.is_flush) begin
            if (out_free) begin
              q_pop                   = 1'b1;
              load                    = 1'b1;
              load_data.out_byte      = q_job.in_byte;
              load_data.out_frame_end = q_job.frame_end;
              load_data.run_end       = 1'b1;
              load_data.redirect      = q_job.redirect;
              load_data.port_out      = q_job.redirect ? cfg.redirect_port : 16'd0;
              load_data.matched_count = q_job.count;
            end
          end else begin
            q_pop      = 1'b1;
            start      = 1'b1;
            idx_next   = '0;
            state_next = B_SEND;
          end
        end
      end
      B_SEND: begin
        if (out_free) begin
          load                    = 1'b1;
          load_data.out_byte      = hdr_byte(idx, job.rewrite, cfg, chk, rd_data);
          load_data.out_frame_end = job.frame_end && last;
          load_data.run_end       = last;
          load_data.redirect      = job.redirect;
          load_data.port_out      = job.redirect ? cfg.redirect_port : 16'd0;
          load_data.matched_count = job.count;
          if (last) begin
            state_next  = B_IDLE;
            mem_release = 1'b1;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
    rd_addr = idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= load_data;
    end
    if (start) begin
      job <= q_job;
      chk <= csum_fold(q_job.sum);
    end
  end

endmodule

FILE: rtl/ipv4_match_rewrite_redirect.sv
// ----------------------------------------------------------------------------
// ipv4_match_rewrite_redirect
// Byte-serial IPv4 source match with header rewrite, checksum update and
// redirect marking.
// ----------------------------------------------------------------------------
// The first 42 bytes of a frame are taken one per cycle, while the queue has
// room and the store is free, into a header store and give no response until
// the 42nd or the frame's last byte arrives. The held bytes then leave as a
// burst, one per cycle unless the output stalls, after the flush job has
// passed through the queue and a start step has addressed the store's
// registered read port; later bytes of the frame pass one per cycle unless
// the queue or the output stalls, with one response each, through the queue
// and the output register. The header of the next frame is held off until
// the burst has been read out of the store. Configuration writes are taken
// every cycle.
module ipv4_match_rewrite_redirect import imrr_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  in_t                   req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output out_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  logic             q_push;
  logic             q_ready;
  logic             q_valid;
  logic             q_pop;
  job_t             q_job_in;
  job_t             q_job_out;
  logic             mem_release;
  logic [POS_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  front_status_t    front_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_source_ip <= RST_MATCH_SRC_IP;
      cfg.new_dest_ip     <= RST_NEW_DEST_IP;
      cfg.new_source_mac  <= RST_NEW_SRC_MAC;
      cfg.new_dest_mac    <= RST_NEW_DEST_MAC;
      cfg.match_protocol  <= RST_MATCH_PROTO;
      cfg.redirect_port   <= RST_REDIRECT_PORT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MATCH_SRC_IP:  cfg.match_source_ip <= cfg_data[31:0];
        REG_NEW_DEST_IP:   cfg.new_dest_ip     <= cfg_data[31:0];
        REG_NEW_SRC_MAC:   cfg.new_source_mac  <= cfg_data[47:0];
        REG_NEW_DEST_MAC:  cfg.new_dest_mac    <= cfg_data[47:0];
        REG_MATCH_PROTO:   cfg.match_protocol  <= cfg_data[7:0];
        REG_REDIRECT_PORT: cfg.redirect_port   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  imrr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_job       (q_job_in),
    .mem_release (mem_release),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .status      (front_status)
  );

  imrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (q_job_in),
    .ready   (q_ready),
    .valid   (q_valid),
    .job_out (q_job_out),
    .pop     (q_pop)
  );

  imrr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_job       (q_job_out),
    .q_pop       (q_pop),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .mem_release (mem_release),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

  a_release_owned: assert property (@(posedge clk) disable iff (rst)
    mem_release |-> front_status.mem_busy)
    else $error("header store released while not owned by the back part");

  a_flush_needs_store: assert property (@(posedge clk) disable iff (rst)
    (q_push && !front_status.flushed) |-> !front_status.mem_busy)
    else $error("header flush queued while the store is still being read");

  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.out_frame_end) |-> rsp.run_end)
    else $error("frame end on a response that does not close its run");

  a_port_only_on_redirect: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.redirect) |-> (rsp.port_out == 16'd0))
    else $error("port index reported on a frame that is not redirected");

endmodule
